// File: sv/ttw_pkg.sv
// ttw_pkg: shared types, sizes and codes for the text terminal writer.
// Used by every module of the block but ttw_ram; depends on nothing.
package ttw_pkg;

  localparam int unsigned MAX_COLS    = 128;
  localparam int unsigned MAX_ROWS    = 32;
  localparam int unsigned STORE_DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned COUNT_W     = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CELL_W      = 16;
  localparam int unsigned TAB_STOP    = 4;

  // operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_ATTR = 2'd2;

  // character codes
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] OOB_ATTR = 8'h07;

  localparam logic [7:0] RST_COLS = 8'd80;
  localparam logic [5:0] RST_ROWS = 6'd25;
  localparam logic [7:0] RST_ATTR = 8'h07;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic [6:0] read_col;
    logic [4:0] read_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
  } out_item_t;

  // screen geometry in use, after clamping
  typedef struct packed {
    logic [7:0]         cols;
    logic [5:0]         rows;
    logic [COUNT_W-1:0] total;
    logic [COUNT_W-1:0] last_base;
    logic [7:0]         attr;
  } geom_t;

endpackage

// File: sv/ttw_ram.sv
// ttw_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module ttw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/ttw_cfg.sv
// ttw_cfg: configuration registers and clamped screen geometry.
// Depends on ttw_pkg.
module ttw_cfg import ttw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output geom_t      geom_o
);

  logic [7:0] cols_q, cols_d;
  logic [5:0] rows_q, rows_d;
  logic [7:0] attr_q, attr_d;
  logic [7:0] cols_use;
  logic [5:0] rows_use;
  logic [COUNT_W-1:0] total;

  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    attr_d = attr_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_COLS: cols_d = cfg_data_i;
        CFG_ROWS: rows_d = cfg_data_i[5:0];
        CFG_ATTR: attr_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= RST_COLS;
      rows_q <= RST_ROWS;
      attr_q <= RST_ATTR;
    end else begin
      cols_q <= cols_d;
      rows_q <= rows_d;
      attr_q <= attr_d;
    end
  end

  // zero reads as one, oversize saturates
  always_comb begin
    if (cols_q == '0) begin
      cols_use = 8'd1;
    end else if (cols_q > MAX_COLS) begin
      cols_use = 8'(MAX_COLS);
    end else begin
      cols_use = cols_q;
    end
    if (rows_q == '0) begin
      rows_use = 6'd1;
    end else if (rows_q > MAX_ROWS) begin
      rows_use = 6'(MAX_ROWS);
    end else begin
      rows_use = rows_q;
    end
  end

  assign total = COUNT_W'(rows_use) * COUNT_W'(cols_use);

  assign geom_o.cols      = cols_use;
  assign geom_o.rows      = rows_use;
  assign geom_o.total     = total;
  assign geom_o.last_base = total - COUNT_W'(cols_use);
  assign geom_o.attr      = attr_q;

endmodule

// File: sv/ttw_ctrl.sv
// ttw_ctrl: cursor state and sequencer that drives the screen store
// (character writes, scroll copy, clear sweep, cell reads). Depends on ttw_pkg.
module ttw_ctrl import ttw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  geom_t             geom_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output out_item_t         res_data_o,
  output logic              mem_we_o,
  output logic [ADDR_W-1:0] mem_waddr_o,
  output logic [CELL_W-1:0] mem_wdata_o,
  output logic              mem_re_o,
  output logic [ADDR_W-1:0] mem_raddr_o,
  input  logic [CELL_W-1:0] mem_rdata_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PLAIN  = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_CLEAR  = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_RESP   = 3'd5;

  logic [2:0]         state_q, state_d;
  in_item_t           item_q, item_d;
  logic [6:0]         col_q, col_d;
  logic [4:0]         line_q, line_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [7:0]         ch_q, ch_d;
  logic [COUNT_W-1:0] idx_q, idx_d;
  logic               pend_q, pend_d;
  logic [ADDR_W-1:0]  pend_addr_q, pend_addr_d;
  logic               pend_blank_q, pend_blank_d;
  logic               inb_q, inb_d;

  logic [4:0]         row_sel;
  logic [6:0]         col_sel;
  logic [ADDR_W-1:0]  cell_addr;
  logic [7:0]         col_inc;
  logic               wrap;
  logic [5:0]         line_nx;
  logic [5:0]         line_lf;
  logic [4:0]         rows_last;
  logic               cursor_inb;
  logic [COUNT_W-1:0] scroll_src;
  logic [CELL_W-1:0]  blank_cell;
  logic [2:0]         tab_cnt;

  assign row_sel    = (state_q == ST_READ) ? item_q.read_row : line_q;
  assign col_sel    = (state_q == ST_READ) ? item_q.read_col : col_q;
  assign cell_addr  = ADDR_W'(row_sel) * ADDR_W'(geom_i.cols) + ADDR_W'(col_sel);
  assign col_inc    = {1'b0, col_q} + 8'd1;
  assign wrap       = col_inc >= geom_i.cols;
  assign line_nx    = {1'b0, line_q} + {5'b0, wrap};
  assign line_lf    = {1'b0, line_q} + 6'd1;
  assign rows_last  = 5'(geom_i.rows - 6'd1);
  assign cursor_inb = ({1'b0, col_q} < geom_i.cols) && ({1'b0, line_q} < geom_i.rows);
  assign scroll_src = idx_q + COUNT_W'(geom_i.cols);
  assign blank_cell = {geom_i.attr, CH_SPACE};
  assign tab_cnt    = 3'(TAB_STOP) - 3'(col_q % TAB_STOP);

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    item_d       = item_q;
    col_d        = col_q;
    line_d       = line_q;
    cnt_d        = cnt_q;
    ch_d         = ch_q;
    idx_d        = idx_q;
    pend_d       = 1'b0;
    pend_addr_d  = pend_addr_q;
    pend_blank_d = pend_blank_q;
    inb_d        = inb_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = cell_addr;
    mem_wdata_o  = {geom_i.attr, ch_q};
    mem_re_o     = 1'b0;
    mem_raddr_o  = cell_addr;
    res_valid_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          idx_d  = '0;
          cnt_d  = '0;
          case (in_data_i.opcode)
            OP_PUT: begin
              case (in_data_i.char_code)
                CH_LF: begin
                  col_d = '0;
                  if (line_lf >= geom_i.rows) begin
                    line_d  = rows_last;
                    state_d = ST_SCROLL;
                  end else begin
                    line_d  = line_lf[4:0];
                    state_d = ST_RESP;
                  end
                end
                CH_CR: begin
                  col_d   = '0;
                  state_d = ST_RESP;
                end
                CH_TAB: begin
                  cnt_d   = tab_cnt;
                  ch_d    = CH_SPACE;
                  state_d = ST_PLAIN;
                end
                default: begin
                  cnt_d   = 3'd1;
                  ch_d    = in_data_i.char_code;
                  state_d = ST_PLAIN;
                end
              endcase
            end
            OP_READ:  state_d = ST_READ;
            OP_CLEAR: state_d = ST_CLEAR;
            default:  state_d = ST_RESP;
          endcase
        end
      end

      ST_PLAIN: begin
        // drop the write when the cursor sits outside the screen
        mem_we_o = cursor_inb;
        col_d    = wrap ? 7'd0 : col_inc[6:0];
        cnt_d    = cnt_q - 3'd1;
        idx_d    = '0;
        if (line_nx >= geom_i.rows) begin
          line_d  = rows_last;
          state_d = ST_SCROLL;
        end else begin
          line_d = line_nx[4:0];
          if (cnt_q == 3'd1) begin
            state_d = ST_RESP;
          end
        end
      end

      ST_SCROLL: begin
        // read entry idx+cols, write it to idx in the next cycle
        if (idx_q != geom_i.total) begin
          idx_d        = idx_q + COUNT_W'(1);
          pend_d       = 1'b1;
          pend_addr_d  = idx_q[ADDR_W-1:0];
          pend_blank_d = idx_q >= geom_i.last_base;
          if (idx_q < geom_i.last_base) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = scroll_src[ADDR_W-1:0];
          end
        end
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pend_addr_q;
          mem_wdata_o = pend_blank_q ? blank_cell : mem_rdata_i;
        end
        if (idx_q == geom_i.total && !pend_q) begin
          state_d = (cnt_q == '0) ? ST_RESP : ST_PLAIN;
        end
      end

      ST_CLEAR: begin
        if (idx_q != geom_i.total) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = idx_q[ADDR_W-1:0];
          mem_wdata_o = blank_cell;
          idx_d       = idx_q + COUNT_W'(1);
        end else begin
          col_d   = '0;
          line_d  = '0;
          state_d = ST_RESP;
        end
      end

      ST_READ: begin
        inb_d    = ({1'b0, item_q.read_col} < geom_i.cols) &&
                   ({1'b0, item_q.read_row} < geom_i.rows);
        mem_re_o = inb_d;
        state_d  = ST_RESP;
      end

      ST_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res_data_o.cursor_col = col_q;
    res_data_o.cursor_row = line_q;
    if (item_q.opcode == OP_READ) begin
      if (inb_q) begin
        res_data_o.cell_char = mem_rdata_i[7:0];
        res_data_o.cell_attr = mem_rdata_i[15:8];
      end else begin
        res_data_o.cell_char = CH_SPACE;
        res_data_o.cell_attr = OOB_ATTR;
      end
    end else begin
      res_data_o.cell_char = '0;
      res_data_o.cell_attr = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      line_q  <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      line_q  <= line_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    ch_q         <= ch_d;
    pend_addr_q  <= pend_addr_d;
    pend_blank_q <= pend_blank_d;
    inb_q        <= inb_d;
  end

endmodule

// File: sv/text_terminal_writer.sv
// Text terminal writer: a character-cell screen store with a cursor, taking
// put-character, read-cell and clear requests; one result per request.
// Depends on ttw_pkg, ttw_cfg, ttw_ctrl and ttw_ram.
//
// Every request returns one result: the cell read (read-cell only) and the
// cursor afterwards. A carriage return, an ignored opcode or a newline that
// stays on screen goes straight to the result; an ordinary character writes
// one cell, a tab one space per column written (up to 4), a cell read one
// store read. Whenever the cursor falls past the last row the screen scrolls
// by sweeping the store once, one entry per cycle through the single read and
// single write port of the screen RAM; clear sweeps the same rows*columns
// entries at one write per cycle. A finished result sits in an output
// register, so the next request is taken while it waits. The store comes up
// undefined: issue clear after reset and after a size change. Configuration
// registers are always ready.
module text_terminal_writer import ttw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  geom_t             geom;
  logic              res_valid;
  logic              res_ready;
  out_item_t         res_data;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] mem_rdata;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  assign cfg_ready_o = 1'b1;

  ttw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .geom_o      (geom)
  );

  ttw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ttw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (STORE_DEPTH)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res_data;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: sv/ttw_checker.sv
// ttw_checker: port-level checks on the text terminal writer, bound to the
// top level. Depends on ttw_pkg and text_terminal_writer.
module ttw_checker import ttw_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  logic [1:0] open_q, open_d;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // requests accepted but not yet answered
  always_comb begin
    open_d = open_q;
    if (in_acc && !out_acc) begin
      open_d = open_q + 2'd1;
    end else if (!in_acc && out_acc) begin
      open_d = open_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> open_q != 2'd0)
    else $error("result without an open request");

  a_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q == 2'd2 |-> !in_ready_o)
    else $error("request taken with two requests open");

  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q != 2'd3)
    else $error("more than two requests open");

endmodule

bind text_terminal_writer ttw_checker u_ttw_checker (.*);
